// File: hw/rtl/trac_pkg.sv
// Package for the typed rotate-add checksum block.
// Holds the field kind codes, the per-kind constants and the shared structs.
// No dependencies; the interfaces, the update logic, the top level and the testbench use it.
`default_nettype none

package trac_pkg;

  // Field types and commands carried in the kind field.
  typedef enum logic [3:0] {
    KIND_INT8      = 4'd0,
    KIND_INT16     = 4'd1,
    KIND_INT24     = 4'd2,
    KIND_BOOL      = 4'd3,
    KIND_INT32     = 4'd4,
    KIND_VINT      = 4'd5,
    KIND_LONG      = 4'd6,
    KIND_VLONG     = 4'd7,
    KIND_BYTES     = 4'd8,
    KIND_STRING    = 4'd9,
    KIND_STRREF    = 4'd10,
    KIND_SETENABLE = 4'd11,
    KIND_RESET     = 4'd12,
    KIND_READ      = 4'd13
  } kind_t;

  localparam int unsigned KindWidth = 4;
  localparam int unsigned SumWidth  = 32;

  // Per-kind additive constants.
  localparam logic [31:0] ADD_INT8       = 32'd11;
  localparam logic [31:0] ADD_INT16      = 32'd19;
  localparam logic [31:0] ADD_INT24      = 32'd21;
  localparam logic [31:0] ADD_BOOL_TRUE  = 32'd13;
  localparam logic [31:0] ADD_BOOL_FALSE = 32'd7;
  localparam logic [31:0] ADD_INT32      = 32'd9;
  localparam logic [31:0] ADD_VINT       = 32'd33;
  localparam logic [31:0] ADD_LONG_HI    = 32'd67;
  localparam logic [31:0] ADD_LONG_LO    = 32'd91;
  localparam logic [31:0] ADD_VLONG_HI   = 32'd65;
  localparam logic [31:0] ADD_VLONG_LO   = 32'd88;
  localparam logic [31:0] ADD_BYTES_NULL = 32'd37;
  localparam logic [31:0] ADD_BYTES_LEN  = 32'd38;
  localparam logic [31:0] ADD_STR_NULL   = 32'd27;
  localparam logic [31:0] ADD_STR_LEN    = 32'd28;

  // Signed range check: value plus bias must stay below the limit.
  localparam logic [31:0] BIAS_INT8   = 32'h0000_0080;
  localparam logic [31:0] LIMIT_INT8  = 32'h0000_0100;
  localparam logic [31:0] BIAS_INT16  = 32'h0000_8000;
  localparam logic [31:0] LIMIT_INT16 = 32'h0001_0000;
  localparam logic [31:0] BIAS_INT24  = 32'h0080_0000;
  localparam logic [31:0] LIMIT_INT24 = 32'h0100_0000;

  // One input request.
  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [31:0]          value_low;
    logic [31:0]          value_high;
    logic                 flag;
    logic                 check_range;
  } item_t;

  // One result.
  typedef struct packed {
    logic [SumWidth-1:0] checksum_out;
    logic                enabled;
    logic                range_error;
  } result_t;

  // Checksum state.
  typedef struct packed {
    logic [SumWidth-1:0] running_sum;
    logic [SumWidth-1:0] saved_sum;
    logic                enable_flag;
  } sum_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/trac_if.sv
// Valid/ready channel interfaces for the checksum block's input and result.
// Depends on trac_pkg for the field widths.
`default_nettype none

interface trac_item_if;
  logic                           valid;
  logic                           ready;
  logic [trac_pkg::KindWidth-1:0] kind;
  logic [31:0]                    value_low;
  logic [31:0]                    value_high;
  logic                           flag;
  logic                           check_range;

  modport source (output valid, kind, value_low, value_high, flag, check_range,
                  input ready);
  modport sink (input valid, kind, value_low, value_high, flag, check_range,
                output ready);
endinterface

interface trac_result_if;
  logic                          valid;
  logic                          ready;
  logic [trac_pkg::SumWidth-1:0] checksum_out;
  logic                          enabled;
  logic                          range_error;

  modport source (output valid, checksum_out, enabled, range_error, input ready);
  modport sink (input valid, checksum_out, enabled, range_error, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/trac_update.sv
// Combinational update of the checksum state for one request.
// Depends on trac_pkg for kinds, constants and structs.
`default_nettype none

module trac_update (
  input  trac_pkg::item_t      item,
  input  trac_pkg::sum_state_t state,
  output trac_pkg::sum_state_t state_next,
  output trac_pkg::result_t    res
);

  logic [31:0] rot;
  logic [31:0] long_mid;
  logic [31:0] vlong_mid;
  logic [31:0] biased8;
  logic [31:0] biased16;
  logic [31:0] biased24;
  logic        err;

  // Rotated checksum and the first round of the two 64-bit kinds.
  assign rot       = {state.running_sum[30:0], state.running_sum[31]};
  assign long_mid  = rot + item.value_high + trac_pkg::ADD_LONG_HI;
  assign vlong_mid = rot + item.value_high + trac_pkg::ADD_VLONG_HI;

  // Biased values for the signed range checks.
  assign biased8  = item.value_low + trac_pkg::BIAS_INT8;
  assign biased16 = item.value_low + trac_pkg::BIAS_INT16;
  assign biased24 = item.value_low + trac_pkg::BIAS_INT24;

  // Per-kind state update.
  always_comb begin
    state_next = state;
    err        = 1'b0;
    case (item.kind)
      trac_pkg::KIND_INT8: begin
        err = item.check_range && (biased8 >= trac_pkg::LIMIT_INT8);
        state_next.running_sum = rot + {24'd0, item.value_low[7:0]} + trac_pkg::ADD_INT8;
      end
      trac_pkg::KIND_INT16: begin
        err = item.check_range && (biased16 >= trac_pkg::LIMIT_INT16);
        state_next.running_sum = rot + {16'd0, item.value_low[15:0]} + trac_pkg::ADD_INT16;
      end
      trac_pkg::KIND_INT24: begin
        err = item.check_range && (biased24 >= trac_pkg::LIMIT_INT24);
        state_next.running_sum = rot + {8'd0, item.value_low[23:0]} + trac_pkg::ADD_INT24;
      end
      trac_pkg::KIND_BOOL: begin
        state_next.running_sum = rot + (item.flag ? trac_pkg::ADD_BOOL_TRUE
                                                  : trac_pkg::ADD_BOOL_FALSE);
      end
      trac_pkg::KIND_INT32: begin
        state_next.running_sum = rot + item.value_low + trac_pkg::ADD_INT32;
      end
      trac_pkg::KIND_VINT: begin
        state_next.running_sum = rot + item.value_low + trac_pkg::ADD_VINT;
      end
      trac_pkg::KIND_LONG: begin
        state_next.running_sum = {long_mid[30:0], long_mid[31]} + item.value_low
                                 + trac_pkg::ADD_LONG_LO;
      end
      trac_pkg::KIND_VLONG: begin
        state_next.running_sum = {vlong_mid[30:0], vlong_mid[31]} + item.value_low
                                 + trac_pkg::ADD_VLONG_LO;
      end
      trac_pkg::KIND_BYTES: begin
        state_next.running_sum = rot + (item.flag
            ? item.value_low + trac_pkg::ADD_BYTES_LEN : trac_pkg::ADD_BYTES_NULL);
      end
      trac_pkg::KIND_STRING: begin
        state_next.running_sum = rot + (item.flag
            ? item.value_low + trac_pkg::ADD_STR_LEN : trac_pkg::ADD_STR_NULL);
      end
      trac_pkg::KIND_STRREF: begin
        state_next.running_sum = rot + item.value_low + trac_pkg::ADD_STR_LEN;
      end
      trac_pkg::KIND_SETENABLE: begin
        // Disabling saves the sum; enabling restores it.
        if (state.enable_flag && !item.flag) begin
          state_next.saved_sum = state.running_sum;
        end else if (!state.enable_flag && item.flag) begin
          state_next.running_sum = state.saved_sum;
        end
        state_next.enable_flag = item.flag;
      end
      trac_pkg::KIND_RESET: begin
        state_next.running_sum = '0;
      end
      trac_pkg::KIND_READ: begin
        if (!state.enable_flag) begin
          state_next.running_sum = state.saved_sum;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Effective checksum after the update.
  assign res.checksum_out = state_next.enable_flag ? state_next.running_sum
                                                   : state_next.saved_sum;
  assign res.enabled      = state_next.enable_flag;
  assign res.range_error  = err;

endmodule

`default_nettype wire

// File: hw/rtl/typed_rotate_add_checksum_top.sv
// A request accepted into the input register moves on into the result register.
// One request per cycle while the result channel keeps up; the state loop has one register.
// The input register holds a new request while a finished result waits downstream.
// Reset (rst, synchronous, active high): checksum and saved value cleared,
// accumulation enabled, both pipeline registers emptied.
// Depends on trac_pkg, trac_if and trac_update.
`default_nettype none

module typed_rotate_add_checksum_top (
  input  wire logic          clk,
  input  wire logic          rst,
  trac_item_if.sink          item,
  trac_result_if.source      result
);

  trac_pkg::item_t      in_data;
  logic                 in_valid;
  trac_pkg::sum_state_t state;
  trac_pkg::sum_state_t state_next;
  trac_pkg::result_t    res_next;
  trac_pkg::result_t    out_data;
  logic                 out_valid;
  logic                 advance;

  // The stored request moves on when the result register is free or draining.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_data.kind        <= item.kind;
      in_data.value_low   <= item.value_low;
      in_data.value_high  <= item.value_high;
      in_data.flag        <= item.flag;
      in_data.check_range <= item.check_range;
    end
  end

  trac_update u_update (
    .item       (in_data),
    .state      (state),
    .state_next (state_next),
    .res        (res_next)
  );

  // Checksum state, written once per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.running_sum <= '0;
      state.saved_sum   <= '0;
      state.enable_flag <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.checksum_out = out_data.checksum_out;
  assign result.enabled      = out_data.enabled;
  assign result.range_error  = out_data.range_error;

endmodule

`default_nettype wire

// File: hw/rtl/trac_checker.sv
// Port-level assertions for the checksum block, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module trac_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [31:0] checksum_out,
  input wire logic        enabled,
  input wire logic        range_error
);

  // A result held back keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(checksum_out) && $stable(enabled) && $stable(range_error))
    else $error("stalled result changed");

  // With no result pending the block always takes a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("request refused while result register empty");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // An accepted request moves through the input register to the result register if the sink is ready.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) ##1 result_ready |=> result_valid)
    else $error("result missing two cycles after request");

endmodule

bind typed_rotate_add_checksum_top trac_checker u_trac_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .checksum_out (result.checksum_out),
  .enabled      (result.enabled),
  .range_error  (result.range_error)
);

`default_nettype wire

// File: tb/sv/typed_rotate_add_checksum_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for typed_rotate_add_checksum_top: directed and random field requests.
// Depends on trac_pkg, trac_if and the block's RTL; results are checked against a checksum model.

module typed_rotate_add_checksum_top_tb;

  // Kind codes that the block must treat as no-ops.
  localparam logic [3:0] KIND_SPARE_LO = 4'd14;
  localparam logic [3:0] KIND_SPARE_HI = 4'd15;

  localparam int unsigned PhaseItems  = 450;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned SettleCycles = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trac_item_if   item_ch ();
  trac_result_if result_ch ();

  typed_rotate_add_checksum_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #6 clk = ~clk;

  trac_pkg::item_t      pending_reqs[$];
  trac_pkg::result_t    expected_sums[$];
  trac_pkg::sum_state_t sum_model;
  int unsigned          src_idle_pct;
  int unsigned          snk_idle_pct;
  logic                 sink_hold;
  logic                 full_rate_phase;
  int unsigned          fail_count;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  // A signed value is out of range when value plus bias, wrapping, reaches the limit.
  function automatic logic range_bad(input logic [31:0] v, input logic [31:0] bias,
                                     input logic [31:0] limit);
    logic [31:0] shifted;
    shifted = v + bias;
    return shifted >= limit;
  endfunction

  // Advances the checksum model by one request and returns the result it must produce.
  function automatic trac_pkg::result_t checksum_step(input trac_pkg::item_t req);
    logic [31:0]       rot;
    logic [31:0]       v;
    trac_pkg::result_t res;
    rot = rotl1(sum_model.running_sum);
    v = req.value_low;
    res.range_error = 1'b0;
    case (req.kind)
      trac_pkg::KIND_INT8: begin
        res.range_error = req.check_range
                          && range_bad(v, trac_pkg::BIAS_INT8, trac_pkg::LIMIT_INT8);
        sum_model.running_sum = rot + {24'd0, v[7:0]} + trac_pkg::ADD_INT8;
      end
      trac_pkg::KIND_INT16: begin
        res.range_error = req.check_range
                          && range_bad(v, trac_pkg::BIAS_INT16, trac_pkg::LIMIT_INT16);
        sum_model.running_sum = rot + {16'd0, v[15:0]} + trac_pkg::ADD_INT16;
      end
      trac_pkg::KIND_INT24: begin
        res.range_error = req.check_range
                          && range_bad(v, trac_pkg::BIAS_INT24, trac_pkg::LIMIT_INT24);
        sum_model.running_sum = rot + {8'd0, v[23:0]} + trac_pkg::ADD_INT24;
      end
      trac_pkg::KIND_BOOL: begin
        sum_model.running_sum = rot + (req.flag ? trac_pkg::ADD_BOOL_TRUE
                                                : trac_pkg::ADD_BOOL_FALSE);
      end
      trac_pkg::KIND_INT32: sum_model.running_sum = rot + v + trac_pkg::ADD_INT32;
      trac_pkg::KIND_VINT:  sum_model.running_sum = rot + v + trac_pkg::ADD_VINT;
      trac_pkg::KIND_LONG: begin
        sum_model.running_sum = rotl1(rot + req.value_high + trac_pkg::ADD_LONG_HI)
                                + v + trac_pkg::ADD_LONG_LO;
      end
      trac_pkg::KIND_VLONG: begin
        sum_model.running_sum = rotl1(rot + req.value_high + trac_pkg::ADD_VLONG_HI)
                                + v + trac_pkg::ADD_VLONG_LO;
      end
      trac_pkg::KIND_BYTES: begin
        sum_model.running_sum = rot + (req.flag ? v + trac_pkg::ADD_BYTES_LEN
                                                : trac_pkg::ADD_BYTES_NULL);
      end
      trac_pkg::KIND_STRING: begin
        sum_model.running_sum = rot + (req.flag ? v + trac_pkg::ADD_STR_LEN
                                                : trac_pkg::ADD_STR_NULL);
      end
      trac_pkg::KIND_STRREF: sum_model.running_sum = rot + v + trac_pkg::ADD_STR_LEN;
      trac_pkg::KIND_SETENABLE: begin
        // Disabling saves the running value; enabling restores it.
        if (sum_model.enable_flag && !req.flag) begin
          sum_model.saved_sum = sum_model.running_sum;
        end else if (!sum_model.enable_flag && req.flag) begin
          sum_model.running_sum = sum_model.saved_sum;
        end
        sum_model.enable_flag = req.flag;
      end
      trac_pkg::KIND_RESET: sum_model.running_sum = '0;
      trac_pkg::KIND_READ: begin
        if (!sum_model.enable_flag) sum_model.running_sum = sum_model.saved_sum;
      end
      default: ;
    endcase
    res.checksum_out = sum_model.enable_flag ? sum_model.running_sum : sum_model.saved_sum;
    res.enabled = sum_model.enable_flag;
    return res;
  endfunction

  // Random word that often sits near the signed bounds of the given width.
  function automatic logic [31:0] rand_value(input int unsigned width);
    logic [31:0] bound;
    bound = 32'd1 << (width - 1);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 300);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 300);
      3: return bound - 32'd2 + $urandom_range(0, 3);
      default: return -bound - 32'd2 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic trac_pkg::item_t rand_request();
    trac_pkg::item_t req;
    int unsigned     pick;
    int unsigned     width;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      req.kind = 4'($urandom_range(0, 10));
    end else if (pick < 80) begin
      req.kind = trac_pkg::KIND_SETENABLE;
    end else if (pick < 85) begin
      req.kind = trac_pkg::KIND_RESET;
    end else if (pick < 93) begin
      req.kind = trac_pkg::KIND_READ;
    end else begin
      req.kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    end
    case (req.kind)
      trac_pkg::KIND_INT8:  width = 8;
      trac_pkg::KIND_INT16: width = 16;
      trac_pkg::KIND_INT24: width = 24;
      default:              width = 32;
    endcase
    req.value_low   = rand_value(width);
    req.value_high  = rand_value(32);
    req.flag        = 1'($urandom_range(0, 1));
    req.check_range = ($urandom_range(0, 3) != 0);
    return req;
  endfunction

  task automatic push_req(input logic [3:0] kind, input logic [31:0] lo, input logic [31:0] hi,
                          input logic flag, input logic chk);
    pending_reqs.push_back(trac_pkg::item_t'{kind: kind, value_low: lo, value_high: hi,
                                             flag: flag, check_range: chk});
  endtask

  // Holds the sender back until every request has been answered.
  task automatic drain_all();
    while (pending_reqs.size() != 0 || item_ch.valid || expected_sums.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Request driver: predicts on acceptance, then offers the next pending request.
  always @(posedge clk) begin
    trac_pkg::item_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        expected_sums.push_back(checksum_step(
            trac_pkg::item_t'{kind: item_ch.kind,
                              value_low: item_ch.value_low,
                              value_high: item_ch.value_high,
                              flag: item_ch.flag,
                              check_range: item_ch.check_range}));
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = pending_reqs.pop_front();
          item_ch.valid       <= 1'b1;
          item_ch.kind        <= nxt.kind;
          item_ch.value_low   <= nxt.value_low;
          item_ch.value_high  <= nxt.value_high;
          item_ch.flag        <= nxt.flag;
          item_ch.check_range <= nxt.check_range;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest expected checksum.
  always @(posedge clk) begin
    trac_pkg::result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_sums.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: checksum %h enabled %b range_error %b",
                     result_ch.checksum_out, result_ch.enabled, result_ch.range_error);
          fail_count++;
        end else begin
          want = expected_sums.pop_front();
          if (want.checksum_out !== result_ch.checksum_out ||
              want.enabled !== result_ch.enabled ||
              want.range_error !== result_ch.range_error) begin
            if (fail_count < 10)
              $display("mismatch: expected checksum %h enabled %b range_error %b, got %h %b %b",
                       want.checksum_out, want.enabled, want.range_error,
                       result_ch.checksum_out, result_ch.enabled, result_ch.range_error);
            fail_count++;
          end
        end
      end
      result_ch.ready <= !sink_hold && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Long receiver hold-off in the full-rate phase so the block backs up into its input.
  initial begin
    wait (full_rate_phase);
    repeat (40) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Run limit far beyond the slowest correct run.
  initial begin
    #2_400_000;
    $display("FAIL");
    $finish;
  end

  // Stimulus: directed requests, then three random phases with different idling.
  initial begin
    item_ch.valid       = 1'b0;
    item_ch.kind        = '0;
    item_ch.value_low   = '0;
    item_ch.value_high  = '0;
    item_ch.flag        = 1'b0;
    item_ch.check_range = 1'b0;
    result_ch.ready     = 1'b0;
    sum_model       = '{running_sum: '0, saved_sum: '0, enable_flag: 1'b1};
    fail_count      = 0;
    sink_hold       = 1'b0;
    full_rate_phase = 1'b0;
    src_idle_pct    = 16;
    snk_idle_pct    = 67;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Range boundaries of the small signed kinds, with and without the check.
    push_req(trac_pkg::KIND_INT8,  32'h0000_007F, 32'h0, 1'b0, 1'b1);
    push_req(trac_pkg::KIND_INT8,  32'h0000_0080, 32'h0, 1'b0, 1'b1);
    push_req(trac_pkg::KIND_INT8,  32'hFFFF_FF80, 32'h0, 1'b0, 1'b1);
    push_req(trac_pkg::KIND_INT8,  32'hFFFF_FF7F, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_INT16, 32'h0000_7FFF, 32'h0, 1'b0, 1'b1);
    push_req(trac_pkg::KIND_INT16, 32'hFFFF_7FFF, 32'h0, 1'b0, 1'b1);
    push_req(trac_pkg::KIND_INT24, 32'h0080_0000, 32'h0, 1'b0, 1'b1);
    push_req(trac_pkg::KIND_INT24, 32'hFF80_0000, 32'h0, 1'b0, 1'b1);
    // Booleans, full-width words and both 64-bit kinds.
    push_req(trac_pkg::KIND_BOOL,  32'h0, 32'h0, 1'b1, 1'b0);
    push_req(trac_pkg::KIND_BOOL,  32'h0, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_INT32, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_VINT,  32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_LONG,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_VLONG, 32'h0, 32'h8000_0000, 1'b0, 1'b0);
    // Length kinds, absent and present; a string reference ignores its flag.
    push_req(trac_pkg::KIND_BYTES,  32'd5, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_BYTES,  32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0);
    push_req(trac_pkg::KIND_STRING, 32'd9, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_STRING, 32'd3, 32'h0, 1'b1, 1'b0);
    push_req(trac_pkg::KIND_STRREF, 32'd7, 32'h0, 1'b0, 1'b0);
    // Disable, write, disable again and read while disabled, then enable twice, reset and read.
    push_req(trac_pkg::KIND_SETENABLE, 32'h0, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_INT32, 32'h1234_5678, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_SETENABLE, 32'h0, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_READ, 32'h0, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_SETENABLE, 32'h0, 32'h0, 1'b1, 1'b0);
    push_req(trac_pkg::KIND_SETENABLE, 32'h0, 32'h0, 1'b1, 1'b0);
    push_req(trac_pkg::KIND_RESET, 32'h0, 32'h0, 1'b0, 1'b0);
    push_req(trac_pkg::KIND_READ, 32'h0, 32'h0, 1'b0, 1'b0);
    push_req(KIND_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_req(KIND_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);

    repeat (PhaseItems) pending_reqs.push_back(rand_request());
    drain_all();

    src_idle_pct = 67;
    snk_idle_pct = 16;
    repeat (PhaseItems) pending_reqs.push_back(rand_request());
    drain_all();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    full_rate_phase = 1'b1;
    repeat (PhaseItems) pending_reqs.push_back(rand_request());
    drain_all();

    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && expected_sums.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
